@@ design/wavhp_pkg.sv @@
package wavhp_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_SAMPLES,
    ST_DONE,
    ST_DIVIDE
  } wavhp_state_e;

  typedef enum logic [1:0] {
    PUSH_NONE,
    PUSH_REJECT,
    PUSH_SAMPLE,
    PUSH_COUNT
  } push_e;

  typedef struct packed {
    logic  hdr_step;
    logic  smp_step;
    logic  div_start;
    push_e push;
  } wavhp_cmd_t;

  typedef struct packed {
    logic reject;
    logic hdr_last;
    logic smp_emit;
    logic smp_last;
    logic div_busy;
    logic quot_zero;
    logic q_space;
  } wavhp_sts_t;

  localparam logic [1:0] KIND_COUNT  = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [2:0] REASON_RIFF     = 3'd0;
  localparam logic [2:0] REASON_WAVE     = 3'd1;
  localparam logic [2:0] REASON_FMT      = 3'd2;
  localparam logic [2:0] REASON_CHANNELS = 3'd3;
  localparam logic [2:0] REASON_RATE     = 3'd4;
  localparam logic [2:0] REASON_DATA     = 3'd5;
  localparam logic [2:0] REASON_FRAME    = 3'd6;

  localparam logic [5:0] POS_RIFF     = 6'd3;
  localparam logic [5:0] POS_WAVE     = 6'd11;
  localparam logic [5:0] POS_FMT      = 6'd15;
  localparam logic [5:0] POS_CHANNELS = 6'd23;
  localparam logic [5:0] POS_RATE     = 6'd27;
  localparam logic [5:0] POS_FRAME    = 6'd33;
  localparam logic [5:0] POS_DATA     = 6'd39;
  localparam logic [5:0] POS_LAST     = 6'd43;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [23:0] TAG_FMT  = 24'h74_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] CHANNELS_RESET = 16'd2;
  localparam logic [31:0] RATE_RESET     = 32'd44100;

  localparam logic CFG_CHANNELS = 1'b0;
  localparam logic CFG_RATE     = 1'b1;

endpackage

@@ design/wavhp_div.sv @@
module wavhp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quot_o
);
  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] quot_q, quot_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  always_comb begin
    trial  = {rem_q, quot_q[31]};
    ge     = trial >= {1'b0, dvs_q};
    diff   = trial - {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[15:0] : trial[15:0];
      quot_d = {quot_q[30:0], ge};
      cnt_d  = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
endmodule

@@ design/wavhp_dp.sv @@
module wavhp_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wavhp_pkg::in_item_t   in_data_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [31:0]           cfg_data_i,
  input  wavhp_pkg::wavhp_cmd_t cmd_i,
  output wavhp_pkg::wavhp_sts_t sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output wavhp_pkg::out_item_t  out_data_o
);
  import wavhp_pkg::*;

  logic [15:0] exp_ch_q;
  logic [31:0] exp_rate_q;
  logic [31:0] acc_q;
  logic [5:0]  pos_q;
  logic [15:0] frame_bytes_q;
  logic [31:0] frames_left_q;
  logic [15:0] bif_q;
  logic [7:0]  low_q;

  logic [31:0] acc_eff, acc_nxt;
  logic [5:0]  pos_eff;
  logic        fail;
  logic [2:0]  reason;
  logic [16:0] bif_inc;
  logic        div_busy;
  logic [31:0] quot;

  out_item_t   ent_q [2];
  out_item_t   ent_new;
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign acc_eff = in_data_i.file_start ? '0 : acc_q;
  assign pos_eff = in_data_i.file_start ? '0 : pos_q;
  assign acc_nxt = {in_data_i.byte_value, acc_eff[31:8]};
  assign bif_inc = {1'b0, bif_q} + 17'd1;

  always_comb begin
    fail   = 1'b0;
    reason = REASON_RIFF;
    unique case (pos_eff)
      POS_RIFF: begin
        fail   = acc_nxt != TAG_RIFF;
        reason = REASON_RIFF;
      end
      POS_WAVE: begin
        fail   = acc_nxt != TAG_WAVE;
        reason = REASON_WAVE;
      end
      POS_FMT: begin
        fail   = acc_nxt[23:0] != TAG_FMT;
        reason = REASON_FMT;
      end
      POS_CHANNELS: begin
        fail   = acc_nxt[31:16] != exp_ch_q;
        reason = REASON_CHANNELS;
      end
      POS_RATE: begin
        fail   = acc_nxt != exp_rate_q;
        reason = REASON_RATE;
      end
      POS_DATA: begin
        fail   = acc_nxt != TAG_DATA;
        reason = REASON_DATA;
      end
      POS_LAST: begin
        fail   = frame_bytes_q < 16'd2;
        reason = REASON_FRAME;
      end
      default: begin
        fail   = 1'b0;
        reason = REASON_RIFF;
      end
    endcase
  end

  wavhp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_nxt),
    .divisor_i  (frame_bytes_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ch_q   <= CHANNELS_RESET;
      exp_rate_q <= RATE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_CHANNELS) begin
        exp_ch_q <= cfg_data_i[15:0];
      end else begin
        exp_rate_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q         <= '0;
      pos_q         <= '0;
      frame_bytes_q <= '0;
      frames_left_q <= '0;
      bif_q         <= '0;
      low_q         <= '0;
    end else begin
      if (cmd_i.hdr_step) begin
        acc_q <= acc_nxt;
        pos_q <= pos_eff + 6'd1;
        if (pos_eff == POS_FRAME) begin
          frame_bytes_q <= acc_nxt[31:16];
        end
        if (pos_eff == POS_LAST) begin
          bif_q <= '0;
        end
      end
      if (cmd_i.smp_step) begin
        bif_q <= (bif_inc >= {1'b0, frame_bytes_q}) ? '0 : bif_inc[15:0];
        if (bif_q == 16'd0) begin
          low_q <= in_data_i.byte_value;
        end
        if (bif_q == 16'd1) begin
          frames_left_q <= frames_left_q - 32'd1;
        end
      end
      if (cmd_i.push == PUSH_COUNT) begin
        frames_left_q <= quot;
      end
    end
  end

  always_comb begin
    ent_new = '0;
    unique case (cmd_i.push)
      PUSH_REJECT: begin
        ent_new.kind  = KIND_REJECT;
        ent_new.value = {29'd0, reason};
        ent_new.last  = 1'b1;
      end
      PUSH_SAMPLE: begin
        ent_new.kind  = KIND_SAMPLE;
        ent_new.value = {16'd0, in_data_i.byte_value, low_q};
        ent_new.last  = frames_left_q == 32'd1;
      end
      PUSH_COUNT: begin
        ent_new.kind  = KIND_COUNT;
        ent_new.value = quot;
        ent_new.last  = quot == 32'd0;
      end
      default: begin
        ent_new = '0;
      end
    endcase
  end

  assign push        = cmd_i.push != PUSH_NONE;
  assign out_valid_o = cnt_q != 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= ent_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.reject    = fail;
    sts_o.hdr_last  = pos_eff == POS_LAST;
    sts_o.smp_emit  = bif_q == 16'd1;
    sts_o.smp_last  = frames_left_q == 32'd1;
    sts_o.div_busy  = div_busy;
    sts_o.quot_zero = quot == 32'd0;
    sts_o.q_space   = (cnt_q != 2'd2) || pop;
  end
endmodule

@@ design/wavhp_ctrl.sv @@
module wavhp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  file_start_i,
  output logic                  in_ready_o,
  input  wavhp_pkg::wavhp_sts_t sts_i,
  output wavhp_pkg::wavhp_cmd_t cmd_o
);
  import wavhp_pkg::*;

  wavhp_state_e st_q, st_d, ph;
  logic         accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_HEADER;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    st_d       = st_q;
    in_ready_o = (st_q != ST_DIVIDE) && sts_i.q_space;
    accept     = in_valid_i && in_ready_o;
    ph         = file_start_i ? ST_HEADER : st_q;
    if (st_q == ST_DIVIDE) begin
      if (!sts_i.div_busy && sts_i.q_space) begin
        cmd_o.push = PUSH_COUNT;
        st_d       = sts_i.quot_zero ? ST_DONE : ST_SAMPLES;
      end
    end else if (accept) begin
      unique case (ph)
        ST_HEADER: begin
          cmd_o.hdr_step = 1'b1;
          st_d           = ST_HEADER;
          if (sts_i.reject) begin
            cmd_o.push = PUSH_REJECT;
            st_d       = ST_DONE;
          end else if (sts_i.hdr_last) begin
            cmd_o.div_start = 1'b1;
            st_d            = ST_DIVIDE;
          end
        end
        ST_SAMPLES: begin
          cmd_o.smp_step = 1'b1;
          if (sts_i.smp_emit) begin
            cmd_o.push = PUSH_SAMPLE;
            if (sts_i.smp_last) begin
              st_d = ST_DONE;
            end
          end
        end
        default: begin
          st_d = st_q;
        end
      endcase
    end
  end
endmodule

@@ design/wav_header_parse_sample_extract.sv @@
// Channel  | Direction | Signals
// input    | in        | in_valid_i, in_ready_o, in_data_i (byte_value, file_start)
// output   | out       | out_valid_o, out_ready_i, out_data_o (kind, value, last)
// config   | in        | cfg_we_i, cfg_idx_i, cfg_data_i
//
// One byte is taken per cycle while the two-entry result queue has room, except during the division below.
// After the last header byte the frame count comes from a bit-serial divider,
// which holds input ready low until the frame count has been queued.
// Reset loads 2 channels and 44100 Hz, empties the queue and parks at header byte 0.
// A stalled output only stops input once both queue entries are full.
module wav_header_parse_sample_extract (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wavhp_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wavhp_pkg::out_item_t out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);
  import wavhp_pkg::*;

  wavhp_cmd_t cmd;
  wavhp_sts_t sts;

  wavhp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .file_start_i (in_data_i.file_start),
    .in_ready_o   (in_ready_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  wavhp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );
endmodule

@@ design/wavhp_chk.sv @@
module wavhp_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input wavhp_pkg::out_item_t out_data_o
);
  import wavhp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transfer changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.kind == KIND_COUNT || out_data_o.kind == KIND_SAMPLE ||
      out_data_o.kind == KIND_REJECT)
    else $error("undefined result kind");

  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_REJECT |->
      out_data_o.last && out_data_o.value <= {29'd0, REASON_FRAME})
    else $error("bad reject result");

  a_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_SAMPLE |-> out_data_o.value[31:16] == 16'd0)
    else $error("sample wider than 16 bits");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_COUNT |->
      out_data_o.last == (out_data_o.value == 32'd0))
    else $error("frame count last flag wrong");
endmodule

bind wav_header_parse_sample_extract wavhp_chk u_chk (.*);
